// ----- rtl/sha256_pkg.sv -----
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_valid;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } state_t;

    // control from sequencer to round core
    typedef struct packed {
        logic       load;   // copy chain hash into working vars
        logic       step;   // run one round
        logic [5:0] rnd;
        logic       fold;   // add working vars into chain hash
        logic       init;   // restore initial hash
    } core_ctl_t;

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] hash_init(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sha256_round.sv -----
`default_nettype none
// One SHA-256 round per cycle while ctl.step is set; schedule kept as a 16-word sliding window.
module sha256_round
    import sha256_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire core_ctl_t         ctl,
    input  wire logic [15:0][31:0] block,
    input  wire logic [2:0]        rd_idx,
    output logic [31:0]            rd_word
);
    logic [7:0][31:0]  chain_reg, chain_next;
    logic [7:0][31:0]  v_reg, v_next;
    logic [15:0][31:0] w_reg, w_next;
    logic [31:0] wi, s0, s1, wn, e, a, t1, t2;

    assign rd_word = chain_reg[rd_idx];

    always_comb begin
        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        // rounds 0-15 take w straight from the block, later ones extend the window
        wi = (ctl.rnd[5:4] == 2'd0) ? block[ctl.rnd[3:0]] : wn;
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
            + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(ctl.rnd) + wi;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
            + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        chain_next = chain_reg;
        v_next = v_reg;
        w_next = w_reg;
        if (ctl.load) begin
            v_next = chain_reg;
        end else if (ctl.step) begin
            v_next = {v_reg[6], v_reg[5], v_reg[4], v_reg[3] + t1,
                      v_reg[2], v_reg[1], v_reg[0], t1 + t2};
            // window holds the 16 schedule words before the current round
            w_next = {wi, w_reg[15:1]};
        end
        if (ctl.fold) begin
            for (int i = 0; i < 8; i++)
                chain_next[i] = chain_reg[i] + v_reg[i];
        end
        if (ctl.init) begin
            for (int i = 0; i < 8; i++)
                chain_next[i] = hash_init(3'(i));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= hash_init(3'(i));
        end else begin
            chain_reg <= chain_next;
        end
        v_reg <= v_next;
        w_reg <= w_next;
    end
endmodule
`default_nettype wire

// ----- rtl/sha256_stream_digest.sv -----
`default_nettype none
// SHA-256 over a byte stream, one byte per transaction. After a byte that
// neither completes a block nor ends the message, s_ready stays high; a byte
// that completes a 64-byte block keeps s_ready low while its 64 rounds run
// through the one round unit and the fold follows. Each block of padding adds
// a length-and-load step, 64 rounds and a fold, and a pad step first when the
// pad mark has to open a fresh block. The final transaction runs one or two
// such blocks, then presents the eight digest words on m_; s_ready stays low
// until the last word is taken and the initial hash is restored.
module sha256_stream_digest
    import sha256_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);
    state_t state_reg, state_next;
    logic [15:0][31:0] blk_reg, blk_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;   // message ending, padding pending
    logic        two_reg, two_next;   // padding needs a second block
    logic [2:0]  idx_reg, idx_next;
    core_ctl_t   ctl;
    logic [31:0] rd_word;

    sha256_round u_round (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .block(blk_reg),
        .rd_idx(idx_reg), .rd_word(rd_word)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign m_data = '{digest_word: rd_word, word_index: idx_reg,
                      last_word: (idx_reg == 3'd7)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            blk_reg <= '0;
            pos_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            fin_reg <= 1'b0;
            two_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            blk_reg <= blk_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
            rnd_reg <= rnd_next;
            fin_reg <= fin_next;
            two_reg <= two_next;
            idx_reg <= idx_next;
        end
    end

    always_comb begin
        logic [5:0] p;
        logic       full;
        p = pos_reg;
        full = 1'b0;
        state_next = state_reg;
        blk_next = blk_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        rnd_next = rnd_reg;
        fin_next = fin_reg;
        two_next = two_reg;
        idx_next = idx_reg;
        ctl = '0;
        ctl.rnd = rnd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.byte_valid) begin
                        blk_next[p[5:2]][(2'd3 - p[1:0]) * 8 +: 8] = s_data.byte_value;
                        len_next = len_reg + 64'd8;
                        p = p + 6'd1;
                        full = (p == 6'd0);
                    end
                    pos_next = p;
                    if (s_data.last_byte) begin
                        fin_next = 1'b1;
                        if (!full) begin
                            blk_next[p[5:2]][(2'd3 - p[1:0]) * 8 +: 8] = PAD_MARK;
                            two_next = (p >= 6'd56);
                        end else begin
                            two_next = 1'b1;
                        end
                    end
                    if (full) begin
                        state_next = ST_ROUND;
                        ctl.load = 1'b1;
                        rnd_next = '0;
                    end else if (s_data.last_byte) begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_ROUND: begin
                ctl.step = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD: begin
                ctl.fold = 1'b1;
                blk_next = '0;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (two_reg) begin
                    two_next = 1'b0;
                    // block filled by data on the last byte: pad mark only now
                    state_next = (pos_reg == 6'd0) ? ST_PAD : ST_LEN;
                end else begin
                    state_next = ST_EMIT;
                    idx_next = '0;
                end
            end
            ST_PAD: begin
                blk_next[0] = {PAD_MARK, 24'd0};
                state_next = ST_LEN;
            end
            ST_LEN: begin
                blk_next[14] = len_reg[63:32];
                blk_next[15] = len_reg[31:0];
                // defer length when padding spills into a second block
                if (two_reg) begin
                    blk_next[14] = blk_reg[14];
                    blk_next[15] = blk_reg[15];
                end
                ctl.load = 1'b1;
                rnd_next = '0;
                state_next = ST_ROUND;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        ctl.init = 1'b1;
                        state_next = ST_IDLE;
                        fin_next = 1'b0;
                        pos_next = '0;
                        len_next = '0;
                        blk_next = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/sha256_checker.sv -----
`default_nettype none
module sha256_checker
    import sha256_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input open while digest pending");
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_word) |=>
        (m_valid && m_data.word_index == $past(m_data.word_index) + 3'd1))
        else $error("digest word order");
    a_lastw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_word == (m_data.word_index == 3'd7)))
        else $error("last_word mismatch");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("output changed while stalled");
endmodule

bind sha256_stream_digest sha256_checker u_chk (.*);
`default_nettype wire

// ----- dv/sha256_stream_digest_test.sv -----
`timescale 1ns / 100ps
module sha256_stream_digest_test
    import sha256_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    sha256_stream_digest uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    // golden hash state
    logic [31:0] hash_st [8];
    logic [31:0] msg_blk [16];
    logic [5:0]  blk_pos;
    logic [63:0] bit_len;

    in_item_t  byte_q [$];
    out_item_t digest_q [$];
    int        errors;
    int        cycles;
    int        gap_left;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 16; i++) w[i] = msg_blk[i];
        for (int i = 16; i < 64; i++) begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-7]
                 + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
        for (int i = 0; i < 16; i++) msg_blk[i] = '0;
    endtask

    task automatic hash_restart();
        for (int i = 0; i < 8; i++) hash_st[i] = SHA_IV[i];
        for (int i = 0; i < 16; i++) msg_blk[i] = '0;
        blk_pos = '0;
        bit_len = '0;
    endtask

    task automatic put_byte(logic [7:0] b);
        msg_blk[blk_pos[5:2]][(3 - blk_pos[1:0]) * 8 +: 8] = b;
    endtask

    task automatic absorb_byte(in_item_t it);
        out_item_t o;
        if (it.byte_valid) begin
            put_byte(it.byte_value);
            bit_len = bit_len + 64'd8;
            blk_pos = blk_pos + 6'd1;
            if (blk_pos == 6'd0) sha_compress();
        end
        if (it.last_byte) begin
            put_byte(PAD_MARK);
            if (blk_pos >= 6'd56) sha_compress();
            msg_blk[14] = bit_len[63:32];
            msg_blk[15] = bit_len[31:0];
            sha_compress();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_st[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_q.push_back(o);
            end
            hash_restart();
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // stretches with no idling on either side
    logic no_idle = 1'b0;
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) no_idle <= ~no_idle;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
            hash_restart();
        end else begin
            if (s_valid && s_ready) absorb_byte(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left > 0 && !no_idle) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    s_data   <= byte_q.pop_front();
                    s_valid  <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the input backs up
    int hold_left;
    always @(posedge aclk) begin
        if (!aresetn) hold_left <= 0;
        else if (cycles == 400) hold_left <= 800;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0 && !no_idle) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest transaction: %h", m_data);
                errors++;
            end else begin
                exp_w = digest_q.pop_front();
                if (m_data.digest_word !== exp_w.digest_word) begin
                    $error("digest_word exp %h got %h", exp_w.digest_word, m_data.digest_word);
                    errors++;
                end
                if (m_data.word_index !== exp_w.word_index) begin
                    $error("word_index exp %0d got %0d", exp_w.word_index, m_data.word_index);
                    errors++;
                end
                if (m_data.last_word !== exp_w.last_word) begin
                    $error("last_word exp %0b got %0b", exp_w.last_word, m_data.last_word);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sha256_stream_digest_test: FAIL");
            $finish;
        end
    end

    task automatic add_item(logic [7:0] b, logic v, logic l);
        in_item_t it;
        it.byte_value = b;
        it.byte_valid = v;
        it.last_byte  = l;
        byte_q.push_back(it);
    endtask

    task automatic add_message(int len, bit end_on_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) add_item(8'($urandom), 1'b0, 1'b0);
            add_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0) add_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int total;
        int len;
        aresetn  = 1'b0;

        // directed: empty message, idle items, extreme bytes, both ways to end
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'h61, 1'b1, 1'b0);
        add_item(8'h62, 1'b1, 1'b0);
        add_item(8'h63, 1'b1, 1'b1);
        add_item(8'hff, 1'b1, 1'b1);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'h55, 1'b0, 1'b1);
        add_item(8'haa, 1'b0, 1'b1);

        // random messages; lengths around the padding boundaries are favored
        total = byte_q.size();
        while (total < 360) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(54, 57);
                1: len = $urandom_range(62, 65);
                2: len = $urandom_range(0, 3);
                3: len = $urandom_range(110, 130);
                default: len = $urandom_range(4, 50);
            endcase
            if (len > 370 - total) len = 370 - total;
            add_message(len, $urandom_range(0, 1));
            total = byte_q.size() + 0;
            if (total >= 360) break;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (byte_q.size() > 0 || s_valid || digest_q.size() > 0);
        repeat (200) @(posedge aclk);

        if (errors == 0 && digest_q.size() == 0) begin
            $display("sha256_stream_digest_test: PASS");
        end else begin
            $display("sha256_stream_digest_test: FAIL");
        end
        $finish;
    end

endmodule
